### src/shg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shg_pkg;

  localparam int unsigned MAX_CELLS_DEF        = 4096;
  localparam int unsigned ENTRIES_PER_CELL_DEF = 2;

  // register indexes (word addresses on the config port)
  localparam logic [2:0] REG_INV_CELL_SIZE = 3'd0;
  localparam logic [2:0] REG_HASH_MUL_X    = 3'd1;
  localparam logic [2:0] REG_HASH_MUL_Y    = 3'd2;
  localparam logic [2:0] REG_HASH_MUL_Z    = 3'd3;
  localparam logic [2:0] REG_CELLS_IN_USE  = 3'd4;

  localparam logic [31:0] INV_CELL_SIZE_RST = 32'd65536;
  localparam logic [31:0] HASH_MUL_X_RST    = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y_RST    = 32'd19349663;
  localparam logic [31:0] HASH_MUL_Z_RST    = 32'd83492791;
  localparam logic [12:0] CELLS_IN_USE_RST  = 13'd4096;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  typedef enum logic [13:0] {
    S_SWEEP = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_CMUL  = 14'b00000000000100,
    S_CFIX  = 14'b00000000001000,
    S_HMUL  = 14'b00000000010000,
    S_HACC  = 14'b00000000100000,
    S_DIV   = 14'b00000001000000,
    S_CRD   = 14'b00000010000000,
    S_CCHK  = 14'b00000100000000,
    S_ERD   = 14'b00001000000000,
    S_EGET  = 14'b00010000000000,
    S_NEXT  = 14'b00100000000000,
    S_QEND  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

endpackage

`default_nettype wire

### src/shg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module shg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/spatial_hash_grid.sv
`timescale 1ns / 1ps
`default_nettype none

// Insert: three scale and three hash multiplier passes, a bitwise remainder, count read
// and write, then the output push.
// Query: 27 neighbor cells, each hashed, reduced and its count read; each entry then read.
// Clear: a sweep of all MAX_CELLS counts, then a result. One item in flight at a time;
// output stalls hold the sequencer. After reset the count memory is swept to zero
// with s_axis_tready low; config writes are taken always.
module spatial_hash_grid #(
  parameter int unsigned MAX_CELLS        = shg_pkg::MAX_CELLS_DEF,
  parameter int unsigned ENTRIES_PER_CELL = shg_pkg::ENTRIES_PER_CELL_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,  // particle_index[15:0], pos_x, pos_y, pos_z
  input  wire logic [1:0]   s_axis_tuser,  // op
  // result items
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // bucket_index[11:0], accepted, neighbour_index,
                                           // found, two zero pad bits
  output logic              m_axis_tlast,
  // config port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned ENT_AW = $clog2(MAX_CELLS * ENTRIES_PER_CELL);
  localparam int unsigned CNT_W  = $clog2(ENTRIES_PER_CELL + 1);
  localparam int unsigned EI_W   = (ENTRIES_PER_CELL > 1) ? $clog2(ENTRIES_PER_CELL) : 1;

  // ---------------------------------------------------------------- config
  logic [31:0] inv_cell_size;
  logic [31:0] hash_mul_x;
  logic [31:0] hash_mul_y;
  logic [31:0] hash_mul_z;
  logic [12:0] cells_in_use;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_size <= shg_pkg::INV_CELL_SIZE_RST;
      hash_mul_x    <= shg_pkg::HASH_MUL_X_RST;
      hash_mul_y    <= shg_pkg::HASH_MUL_Y_RST;
      hash_mul_z    <= shg_pkg::HASH_MUL_Z_RST;
      cells_in_use  <= shg_pkg::CELLS_IN_USE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        shg_pkg::REG_INV_CELL_SIZE: inv_cell_size <= pwdata;
        shg_pkg::REG_HASH_MUL_X:    hash_mul_x    <= pwdata;
        shg_pkg::REG_HASH_MUL_Y:    hash_mul_y    <= pwdata;
        shg_pkg::REG_HASH_MUL_Z:    hash_mul_z    <= pwdata;
        shg_pkg::REG_CELLS_IN_USE:  cells_in_use  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      shg_pkg::REG_INV_CELL_SIZE: prdata = inv_cell_size;
      shg_pkg::REG_HASH_MUL_X:    prdata = hash_mul_x;
      shg_pkg::REG_HASH_MUL_Y:    prdata = hash_mul_y;
      shg_pkg::REG_HASH_MUL_Z:    prdata = hash_mul_z;
      shg_pkg::REG_CELLS_IN_USE:  prdata = {19'd0, cells_in_use};
      default:                    prdata = 32'd0;
    endcase
  end

  // Clamp the modulus into 1..MAX_CELLS.
  logic [31:0]       nmod32;
  logic [CELL_W:0]   nmod;
  always_comb begin
    if (cells_in_use == 13'd0) begin
      nmod32 = 32'd1;
    end else if ({19'd0, cells_in_use} > MAX_CELLS) begin
      nmod32 = MAX_CELLS;
    end else begin
      nmod32 = {19'd0, cells_in_use};
    end
  end
  assign nmod = nmod32[CELL_W:0];

  // ---------------------------------------------------------------- item regs
  shg_pkg::state_t state;
  logic [1:0]        opr;
  logic [15:0]       pidx;
  logic [31:0]       pos [3];
  logic [31:0]       crd [3];
  logic [1:0]        off [3];       // neighbor offset per axis, 0..2 means -1..+1
  logic [1:0]        ax;
  logic [63:0]       prod;
  logic [31:0]       h;
  logic [4:0]        bitcnt;
  logic [CELL_W-1:0] rem;
  logic [CELL_W-1:0] swp;
  logic              sweep_rsp;
  logic              ok;
  logic [EI_W-1:0]   eidx;
  logic [CNT_W-1:0]  ncnt;
  logic [15:0]       pend;
  logic              pend_v;

  // ---------------------------------------------------------------- output reg
  logic        out_valid;
  logic [11:0] out_bucket;
  logic        out_acc;
  logic [15:0] out_nidx;
  logic        out_found;
  logic        out_last;
  logic        out_free;

  assign out_free      = ~out_valid | m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_found, out_nidx, out_acc, out_bucket};
  assign m_axis_tlast  = out_last;
  assign s_axis_tready = (state == shg_pkg::S_IDLE);

  // ---------------------------------------------------------------- shared multiplier
  logic [31:0] pos_cur;
  logic [31:0] mag;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] coord;
  logic [31:0] hmul_cur;
  logic [31:0] q;

  assign pos_cur = pos[ax];
  assign mag     = pos_cur[31] ? (32'd0 - pos_cur) : pos_cur;
  assign coord   = crd[ax] + {30'd0, off[ax]} - 32'd1;
  assign q       = prod[63:32];

  always_comb begin
    case (ax)
      2'd0:    hmul_cur = hash_mul_x;
      2'd1:    hmul_cur = hash_mul_y;
      default: hmul_cur = hash_mul_z;
    endcase
  end

  always_comb begin
    if (state == shg_pkg::S_CMUL) begin
      mul_a = mag;
      mul_b = inv_cell_size;
    end else begin
      mul_a = coord;
      mul_b = hmul_cur;
    end
  end

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  // ---------------------------------------------------------------- remainder step
  logic [CELL_W:0]   rtry;
  logic [CELL_W-1:0] rem_next;
  assign rtry = {rem, h[bitcnt]};
  always_comb begin
    if (rtry >= nmod) begin
      rem_next = CELL_W'(rtry - nmod);
    end else begin
      rem_next = rtry[CELL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- memories
  logic              cnt_we;
  logic [CELL_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              ent_we;
  logic [ENT_AW-1:0] ent_base;
  logic [ENT_AW-1:0] ent_waddr;
  logic [ENT_AW-1:0] ent_raddr;
  logic [15:0]       ent_rdata;
  logic              room;
  logic [31:0]       cnt32;
  logic [31:0]       rem32;
  logic              last_ent;

  assign cnt32     = 32'(cnt_rdata);
  assign rem32     = 32'(rem);
  assign room      = cnt32 < ENTRIES_PER_CELL;
  assign ent_base  = ENT_AW'(rem) * ENT_AW'(ENTRIES_PER_CELL);
  assign ent_waddr = ent_base + ENT_AW'(cnt_rdata);
  assign ent_raddr = ent_base + ENT_AW'(eidx);
  assign last_ent  = (32'(eidx) + 32'd1) == 32'(ncnt);

  // Sweep writes zero; insert, if the bucket has room, bumps its count and stores the entry.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = rem;
    cnt_wdata = CNT_W'(cnt32 + 32'd1);
    ent_we    = 1'b0;
    if (state == shg_pkg::S_SWEEP) begin
      cnt_we    = 1'b1;
      cnt_waddr = swp;
      cnt_wdata = '0;
    end else if (state == shg_pkg::S_CCHK && opr == shg_pkg::OP_INSERT && room) begin
      cnt_we = 1'b1;
      ent_we = 1'b1;
    end
  end

  shg_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (rem),
    .rdata (cnt_rdata)
  );

  shg_ram #(.WIDTH(16), .DEPTH(MAX_CELLS * ENTRIES_PER_CELL)) u_entry (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (pidx),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shg_pkg::S_SWEEP;
      swp       <= '0;
      sweep_rsp <= 1'b0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      // drop the result once the sink takes it; a push below overrides
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        shg_pkg::S_SWEEP: begin
          swp <= swp + 1'b1;
          if (swp == CELL_W'(MAX_CELLS - 1)) begin
            state <= sweep_rsp ? shg_pkg::S_OUT : shg_pkg::S_IDLE;
          end
        end

        shg_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            opr    <= s_axis_tuser;
            pidx   <= s_axis_tdata[15:0];
            pos[0] <= s_axis_tdata[47:16];
            pos[1] <= s_axis_tdata[79:48];
            pos[2] <= s_axis_tdata[111:80];
            ax     <= 2'd0;
            pend_v <= 1'b0;
            case (s_axis_tuser)
              shg_pkg::OP_INSERT: begin
                off[0] <= 2'd1;
                off[1] <= 2'd1;
                off[2] <= 2'd1;
                state  <= shg_pkg::S_CMUL;
              end
              shg_pkg::OP_QUERY: begin
                off[0] <= 2'd0;
                off[1] <= 2'd0;
                off[2] <= 2'd0;
                state  <= shg_pkg::S_CMUL;
              end
              shg_pkg::OP_CLEAR: begin
                swp       <= '0;
                sweep_rsp <= 1'b1;
                state     <= shg_pkg::S_SWEEP;
              end
              default: state <= shg_pkg::S_OUT;
            endcase
          end
        end

        // scale one axis by the inverse cell size
        shg_pkg::S_CMUL: state <= shg_pkg::S_CFIX;

        shg_pkg::S_CFIX: begin
          crd[ax] <= pos_cur[31] ? (32'd0 - q) : q;
          if (ax == 2'd2) begin
            ax    <= 2'd0;
            h     <= 32'd0;
            state <= shg_pkg::S_HMUL;
          end else begin
            ax    <= ax + 2'd1;
            state <= shg_pkg::S_CMUL;
          end
        end

        // fold one axis product into the hash
        shg_pkg::S_HMUL: state <= shg_pkg::S_HACC;

        shg_pkg::S_HACC: begin
          h <= h ^ prod[31:0];
          if (ax == 2'd2) begin
            bitcnt <= 5'd31;
            rem    <= '0;
            state  <= shg_pkg::S_DIV;
          end else begin
            ax    <= ax + 2'd1;
            state <= shg_pkg::S_HMUL;
          end
        end

        // one quotient bit a cycle, MSB first
        shg_pkg::S_DIV: begin
          rem    <= rem_next;
          bitcnt <= bitcnt - 5'd1;
          if (bitcnt == 5'd0) begin
            state <= shg_pkg::S_CRD;
          end
        end

        shg_pkg::S_CRD: state <= shg_pkg::S_CCHK;

        shg_pkg::S_CCHK: begin
          if (opr == shg_pkg::OP_INSERT) begin
            ok    <= room;
            state <= shg_pkg::S_OUT;
          end else begin
            ncnt  <= (cnt32 > ENTRIES_PER_CELL) ? CNT_W'(ENTRIES_PER_CELL) : cnt_rdata;
            eidx  <= '0;
            state <= (cnt_rdata == '0) ? shg_pkg::S_NEXT : shg_pkg::S_ERD;
          end
        end

        shg_pkg::S_ERD: state <= shg_pkg::S_EGET;

        // hold one entry back so the final one can carry tlast
        shg_pkg::S_EGET: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              out_valid  <= 1'b1;
              out_bucket <= 12'd0;
              out_acc    <= 1'b0;
              out_nidx   <= pend;
              out_found  <= 1'b1;
              out_last   <= 1'b0;
            end
            pend   <= ent_rdata;
            pend_v <= 1'b1;
            if (last_ent) begin
              state <= shg_pkg::S_NEXT;
            end else begin
              eidx  <= eidx + 1'b1;
              state <= shg_pkg::S_ERD;
            end
          end
        end

        // advance z, then y, then x
        shg_pkg::S_NEXT: begin
          ax    <= 2'd0;
          h     <= 32'd0;
          state <= shg_pkg::S_HMUL;
          if (off[2] == 2'd2) begin
            off[2] <= 2'd0;
            if (off[1] == 2'd2) begin
              off[1] <= 2'd0;
              if (off[0] == 2'd2) begin
                state <= shg_pkg::S_QEND;
              end else begin
                off[0] <= off[0] + 2'd1;
              end
            end else begin
              off[1] <= off[1] + 2'd1;
            end
          end else begin
            off[2] <= off[2] + 2'd1;
          end
        end

        shg_pkg::S_QEND: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_bucket <= 12'd0;
            out_acc    <= 1'b0;
            out_nidx   <= pend_v ? pend : 16'd0;
            out_found  <= pend_v;
            out_last   <= 1'b1;
            pend_v     <= 1'b0;
            state      <= shg_pkg::S_IDLE;
          end
        end

        shg_pkg::S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_nidx  <= 16'd0;
            out_found <= 1'b0;
            out_last  <= 1'b1;
            if (opr == shg_pkg::OP_INSERT) begin
              out_bucket <= rem32[11:0];
              out_acc    <= ok;
            end else begin
              out_bucket <= 12'd0;
              out_acc    <= 1'b0;
            end
            sweep_rsp <= 1'b0;
            state     <= shg_pkg::S_IDLE;
          end
        end

        default: state <= shg_pkg::S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sim/shg_checker.sv
`timescale 1ns / 1ps

module shg_checker
  import shg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fails,
  output int           waiting
);

  typedef struct packed {
    logic [11:0] bucket;
    logic        stored;
    logic [15:0] neighbour;
    logic        hit;
    logic        tail;
  } grid_result_t;

  grid_result_t grid_results_q[$];

  logic [31:0] inv_cell;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [31:0] mul_z;
  logic [12:0] cells;

  int          fill[MAX_CELLS_DEF];
  logic [15:0] slots[MAX_CELLS_DEF * ENTRIES_PER_CELL_DEF];

  task automatic flag(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fails++;
  endtask

  // truncate pos * inv_cell / 2^32 toward zero, keep low 32 bits
  function automatic logic [31:0] to_cell(input logic [31:0] p);
    logic [63:0] mag;
    logic [63:0] q;
    mag = p[31] ? {32'd0, 32'd0 - p} : {32'd0, p};
    q = (mag * {32'd0, inv_cell}) >> 32;
    return p[31] ? 32'd0 - q[31:0] : q[31:0];
  endfunction

  function automatic logic [31:0] bucket_of(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z);
    logic [31:0] h;
    logic [31:0] m;
    h = (x * mul_x) ^ (y * mul_y) ^ (z * mul_z);
    m = (cells == 0) ? 1 : (cells > MAX_CELLS_DEF) ? MAX_CELLS_DEF : cells;
    return h % m;
  endfunction

  task automatic file_grid_item(input logic [1:0] op, input logic [111:0] d);
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [31:0] b;
    grid_result_t r;
    int n;
    cx = to_cell(d[47:16]);
    cy = to_cell(d[79:48]);
    cz = to_cell(d[111:80]);
    r = '0;
    r.tail = 1'b1;
    n = 0;
    if (op == OP_INSERT) begin
      b = bucket_of(cx, cy, cz);
      r.bucket = b[11:0];
      if (fill[b] < ENTRIES_PER_CELL_DEF) begin
        slots[b * ENTRIES_PER_CELL_DEF + fill[b]] = d[15:0];
        fill[b]++;
        r.stored = 1'b1;
      end
      grid_results_q.push_back(r);
    end else if (op == OP_QUERY) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++) begin
            b = bucket_of(cx + i - 1, cy + j - 1, cz + k - 1);
            for (int e = 0; e < fill[b]; e++) begin
              r = '0;
              r.hit = 1'b1;
              r.neighbour = slots[b * ENTRIES_PER_CELL_DEF + e];
              grid_results_q.push_back(r);
              n++;
            end
          end
      if (n == 0) begin
        r = '0;
        r.tail = 1'b1;
        grid_results_q.push_back(r);
      end else begin
        grid_results_q[grid_results_q.size() - 1].tail = 1'b1;
      end
    end else begin
      if (op == OP_CLEAR)
        for (int c = 0; c < MAX_CELLS_DEF; c++) fill[c] = 0;
      grid_results_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    grid_result_t w;
    if (rst) begin
      inv_cell = INV_CELL_SIZE_RST;
      mul_x = HASH_MUL_X_RST;
      mul_y = HASH_MUL_Y_RST;
      mul_z = HASH_MUL_Z_RST;
      cells = CELLS_IN_USE_RST;
      for (int c = 0; c < MAX_CELLS_DEF; c++) fill[c] = 0;
      grid_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_INV_CELL_SIZE: inv_cell = pwdata;
          REG_HASH_MUL_X:    mul_x = pwdata;
          REG_HASH_MUL_Y:    mul_y = pwdata;
          REG_HASH_MUL_Z:    mul_z = pwdata;
          REG_CELLS_IN_USE:  cells = pwdata[12:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (grid_results_q.size() == 0) begin
          flag($sformatf("result %h with nothing outstanding", m_axis_tdata));
        end else begin
          w = grid_results_q.pop_front();
          if (m_axis_tdata[11:0] !== w.bucket)
            flag($sformatf("bucket %0d, want %0d", m_axis_tdata[11:0], w.bucket));
          if (m_axis_tdata[12] !== w.stored)
            flag($sformatf("accepted %b, want %b", m_axis_tdata[12], w.stored));
          if (m_axis_tdata[28:13] !== w.neighbour)
            flag($sformatf("neighbour %h, want %h", m_axis_tdata[28:13], w.neighbour));
          if (m_axis_tdata[29] !== w.hit)
            flag($sformatf("found %b, want %b", m_axis_tdata[29], w.hit));
          if (m_axis_tlast !== w.tail)
            flag($sformatf("last %b, want %b", m_axis_tlast, w.tail));
        end
      end
      if (s_axis_tvalid && s_axis_tready) file_grid_item(s_axis_tuser, s_axis_tdata);
    end
    waiting = grid_results_q.size();
  end

endmodule

### sim/tb_spatial_hash_grid.sv
`timescale 1ns / 1ps

module tb_spatial_hash_grid;
  import shg_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;  // particle_index, pos_x, pos_y, pos_z
  logic [1:0]   s_axis_tuser = OP_INSERT;  // op
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;  // bucket_index, accepted, neighbour_index, found, pad
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int fails;
  int waiting;
  bit no_idle = 1'b0;  // set for stretches with back-to-back traffic on both sides
  int stall_left = 0;

  spatial_hash_grid u_top (.*);

  shg_checker u_chk (.*);

  always #10 clk = ~clk;

  // Pick an idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result side at random; hold ready high while no_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one item and hold it until the block takes it. Lower valid only when
  // a gap follows, so valid never drops and rises within one step.
  task automatic send(input logic [1:0] op, input logic [15:0] idx, input logic [31:0] x,
                      input logic [31:0] y, input logic [31:0] z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tuser <= op;
    s_axis_tdata <= {z, y, x, idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending and let every outstanding result drain, plus slack for the FSM.
  // Step one edge first so the checker has counted the item just taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_grid(input logic [31:0] inv, input logic [31:0] mx,
                          input logic [31:0] my, input logic [31:0] mz,
                          input logic [31:0] n);
    reg_write(REG_INV_CELL_SIZE, inv);
    reg_write(REG_HASH_MUL_X, mx);
    reg_write(REG_HASH_MUL_Y, my);
    reg_write(REG_HASH_MUL_Z, mz);
    reg_write(REG_CELLS_IN_USE, n);
  endtask

  // Mostly positions within a few cells of the origin so that buckets fill
  // and queries find neighbors; the rest anywhere in the 32-bit range.
  function automatic logic [31:0] spot();
    int k;
    if ($urandom_range(0, 4) == 0) return $urandom;
    k = int'($urandom_range(0, 6)) - 3;
    return (k <<< 16) + $urandom_range(0, 65535);
  endfunction

  task automatic random_item();
    int r;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < 55) op = OP_INSERT;
    else if (r < 93) op = OP_QUERY;
    else if (r < 96) op = OP_CLEAR;
    else op = OP_RSVD;
    send(op, 16'($urandom_range(0, 65535)), spot(), spot(), spot());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill one bucket past capacity, then look around it.
    send(OP_INSERT, 16'h0000, 32'h0, 32'h0, 32'h0);
    send(OP_INSERT, 16'hFFFF, 32'h0, 32'h0, 32'h0);
    send(OP_INSERT, 16'h1234, 32'h0, 32'h0, 32'h0);  // bucket full: dropped
    send(OP_QUERY, 16'h0, 32'h0, 32'h0, 32'h0);
    // Small negatives truncate toward zero, not down.
    send(OP_INSERT, 16'h0001, 32'hFFFFFFFF, 32'hFFFE8000, 32'hFFFF0001);
    send(OP_INSERT, 16'hAAAA, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000);
    send(OP_QUERY, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000);
    send(OP_QUERY, 16'h0, 32'h03E80000, 32'hFC180000, 32'h01000000);
    send(OP_RSVD, 16'h5555, 32'h0, 32'h0, 32'h0);  // unused op: no state change
    send(OP_QUERY, 16'h0, 32'h0, 32'h0, 32'h0);
    send(OP_CLEAR, 16'h0, 32'h0, 32'h0, 32'h0);
    send(OP_QUERY, 16'h0, 32'h0, 32'h0, 32'h0);  // empty after clear
    send(OP_INSERT, 16'h5555, 32'h7FFFFFFF, 32'h80000000, 32'h00000000);
    send(OP_QUERY, 16'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000);

    // Random phases, each under its own grid setting. The drain before each
    // write is also the pause that lets all results come home.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: set_grid(32'h00008000, $urandom, $urandom, $urandom, 13);
          // every cell in one bucket: queries return the most results
          2: set_grid(32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h1, 0);
          3: set_grid(32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8191);
          default: set_grid(32'h00020000, $urandom, $urandom, $urandom, 4096);
        endcase
      end
      no_idle = (ph == 2);
      for (int i = 0; i < 72; i++) random_item();
    end
    no_idle = 1'b0;

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("PASS spatial_hash_grid");
    end else begin
      $display("FAIL spatial_hash_grid");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #200ms;
    $display("FAIL spatial_hash_grid");
    $finish;
  end

endmodule

### files.f
src/shg_pkg.sv
src/shg_ram.sv
src/spatial_hash_grid.sv
sim/shg_checker.sv
sim/tb_spatial_hash_grid.sv
